// File: rtl/animation_playback_timer_top_defines.svh
// ----------------------------------------------------------------------------
// Animation playback timer assertion macros
// Shared concurrent assertion forms for the timer checker.
// ----------------------------------------------------------------------------
`ifndef ANIMATION_PLAYBACK_TIMER_TOP_DEFINES_SVH
`define ANIMATION_PLAYBACK_TIMER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define APT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define APT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// Types, widths and codes shared by the animation playback timer.
// ----------------------------------------------------------------------------
package apt_pkg;

  localparam int TIME_BITS     = 40;  // signed Q32.8 ms
  localparam int RATE_BITS     = 16;  // signed Q8.8
  localparam int FRAC_BITS     = 8;
  localparam int DUR_BITS      = 39;  // unsigned Q31.8 ms
  localparam int CNT_BITS      = 24;  // unsigned Q16.8
  localparam int CMD_BITS      = 3;
  localparam int STATE_BITS    = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = DUR_BITS;

  // Stream packing, first field in the lowest bits
  localparam int IN_FIELD_BITS  = CMD_BITS + 2 * TIME_BITS + RATE_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = STATE_BITS + 2 * TIME_BITS + RATE_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int IN_DELTA_LSB = CMD_BITS;
  localparam int IN_NTIME_LSB = IN_DELTA_LSB + TIME_BITS;
  localparam int IN_NRATE_LSB = IN_NTIME_LSB + TIME_BITS;

  typedef logic signed [TIME_BITS-1:0] time_t;
  typedef logic signed [RATE_BITS-1:0] rate_t;

  localparam time_t T_MAX = {1'b0, {(TIME_BITS-1){1'b1}}};
  localparam time_t T_MIN = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam rate_t R_MAX = {1'b0, {(RATE_BITS-1){1'b1}}};
  localparam rate_t R_MIN = {1'b1, {(RATE_BITS-1){1'b0}}};
  localparam rate_t RATE_ONE     = rate_t'(2 ** FRAC_BITS);
  // infinite duration stands for -1.0 ms in the finished set-time check
  localparam time_t INF_CMP_TIME = -time_t'(2 ** FRAC_BITS);

  typedef enum logic [CMD_BITS-1:0] {
    CMD_TICK,
    CMD_PLAY,
    CMD_PAUSE,
    CMD_REVERSE,
    CMD_CANCEL,
    CMD_FINISH,
    CMD_SET_TIME,
    CMD_SET_RATE
  } cmd_e;

  typedef enum logic [STATE_BITS-1:0] {
    ST_IDLE,
    ST_RUNNING,
    ST_PAUSED,
    ST_FINISHED
  } pstate_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_EFFECT,
    CFG_ITER_DUR,
    CFG_ITER_CNT,
    CFG_INFINITE,
    CFG_TIMELINE
  } cfg_idx_e;

  typedef struct packed {
    pstate_e mode;
    time_t   anim_time;
    rate_t   rate;
    time_t   clock_time;
  } anim_state_t;

  typedef struct packed {
    cmd_e  cmd;
    time_t delta_time;
    time_t seek_time;
    rate_t new_rate;
  } cmd_item_t;

  // Derived timing seen by the command logic
  typedef struct packed {
    time_t active_dur;
    logic  infinite;
    logic  timeline_present;
  } timing_t;

endpackage

// File: rtl/animation_playback_timer_top.sv
// ----------------------------------------------------------------------------
// animation_playback_timer_top
// Animation playback timer: play state, time, rate and timeline clock.
// ----------------------------------------------------------------------------
// Each input item carries one command (tick, play, pause, reverse, cancel,
// finish, set time, set rate) and yields exactly one result item with the
// play state, animation time, playback rate and timeline clock after it.
// The block takes one item per clock cycle while the output is not stalled;
// the item lands in the input register at the accepting edge, and the
// state/result register loads from it once the result slot is free. The
// tick path, which does the delta-times-rate multiply, the saturating add
// and the compare against the active duration, lies combinationally
// between the two registers. The output side
// may stall freely: one further item waits in the input register and
// ready drops only when both stages are full. Active duration (iteration
// duration times count) is recomputed from each configuration write on the
// same edge. Configuration writes must land while no item is in flight.
// There is no post-reset clearing pass.
// ----------------------------------------------------------------------------
module animation_playback_timer_top
  import apt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // cmd, delta_time, seek_time, new_rate (low to high), zero padded
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // result stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // mode, anim_time, rate, clock_time (low to high), zero padded
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  // configuration write port
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i
);

  logic        in_valid_q, in_valid_d;
  cmd_item_t   in_item_q;
  cmd_item_t   in_item;
  logic        out_valid_q, out_valid_d;
  anim_state_t state_q, state_d;
  anim_state_t state_next;
  timing_t     timing;

  logic s_accept;
  logic out_free;
  logic advance;

  // handshake: the state register doubles as the result register
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // unpack the command item
  assign in_item.cmd        = cmd_e'(s_axis_tdata[CMD_BITS-1:0]);
  assign in_item.delta_time = s_axis_tdata[IN_DELTA_LSB +: TIME_BITS];
  assign in_item.seek_time  = s_axis_tdata[IN_NTIME_LSB +: TIME_BITS];
  assign in_item.new_rate   = s_axis_tdata[IN_NRATE_LSB +: RATE_BITS];

  apt_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .timing_o    (timing)
  );

  apt_core u_core (
    .state_i  (state_q),
    .item_i   (in_item_q),
    .timing_i (timing),
    .state_o  (state_next)
  );

  always_comb begin
    in_valid_d  = in_valid_q;
    out_valid_d = out_valid_q;
    state_d     = state_q;
    if (advance) begin
      in_valid_d = 1'b0;
    end
    if (s_accept) begin
      in_valid_d = 1'b1;
    end
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      state_d     = state_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{mode: ST_IDLE, anim_time: '0, rate: RATE_ONE, clock_time: '0};
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      state_q     <= state_d;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_item_q <= in_item;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_BITS'({state_q.clock_time, state_q.rate,
                                         state_q.anim_time, state_q.mode});

endmodule

// File: rtl/apt_cfg.sv
// ----------------------------------------------------------------------------
// apt_cfg
// Configuration registers and registered active duration.
// ----------------------------------------------------------------------------
module apt_cfg
  import apt_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  output timing_t                  timing_o
);

  localparam int PROD_BITS = DUR_BITS + CNT_BITS;

  logic                effect_q, effect_d;
  logic [DUR_BITS-1:0] dur_q, dur_d;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                inf_q, inf_d;
  logic                tl_q, tl_d;
  time_t               ad_q, ad_d;
  logic                inf_flag_q, inf_flag_d;

  logic [PROD_BITS-1:0] prod;
  logic [63:0]          q64;

  always_comb begin
    effect_d = effect_q;
    dur_d    = dur_q;
    cnt_d    = cnt_q;
    inf_d    = inf_q;
    tl_d     = tl_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_EFFECT:   effect_d = cfg_wdata_i[0];
        CFG_ITER_DUR: dur_d    = cfg_wdata_i[DUR_BITS-1:0];
        CFG_ITER_CNT: cnt_d    = cfg_wdata_i[CNT_BITS-1:0];
        CFG_INFINITE: inf_d    = cfg_wdata_i[0];
        CFG_TIMELINE: tl_d     = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Duration follows the value being written, so it is current on the same
  // edge as the register itself
  always_comb begin
    prod = PROD_BITS'(dur_d) * PROD_BITS'(cnt_d);
    q64  = 64'(prod[PROD_BITS-1:FRAC_BITS]);
    if (!effect_d) begin
      ad_d = '0;
    end else if (q64 > 64'(T_MAX)) begin
      ad_d = T_MAX;
    end else begin
      ad_d = time_t'(q64[TIME_BITS-1:0]);
    end
    inf_flag_d = effect_d & inf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      effect_q   <= 1'b1;
      dur_q      <= '0;
      cnt_q      <= CNT_BITS'(2 ** FRAC_BITS);
      inf_q      <= 1'b0;
      tl_q       <= 1'b1;
      ad_q       <= '0;
      inf_flag_q <= 1'b0;
    end else begin
      effect_q   <= effect_d;
      dur_q      <= dur_d;
      cnt_q      <= cnt_d;
      inf_q      <= inf_d;
      tl_q       <= tl_d;
      ad_q       <= ad_d;
      inf_flag_q <= inf_flag_d;
    end
  end

  assign timing_o.active_dur       = ad_q;
  assign timing_o.infinite         = inf_flag_q;
  assign timing_o.timeline_present = tl_q;

endmodule

// File: rtl/apt_core.sv
// ----------------------------------------------------------------------------
// apt_core
// Next playback state for one command.
// ----------------------------------------------------------------------------
module apt_core
  import apt_pkg::*;
(
  input  anim_state_t state_i,
  input  cmd_item_t   item_i,
  input  timing_t     timing_i,
  output anim_state_t state_o
);

  localparam int MUL_BITS = TIME_BITS + RATE_BITS;
  localparam int Q_BITS   = MUL_BITS - FRAC_BITS;

  function automatic time_t sat_add(time_t a, time_t b);
    logic signed [TIME_BITS:0] s;
    s = {a[TIME_BITS-1], a} + {b[TIME_BITS-1], b};
    if (s[TIME_BITS] != s[TIME_BITS-1]) begin
      return s[TIME_BITS] ? T_MIN : T_MAX;
    end
    return s[TIME_BITS-1:0];
  endfunction

  // (a * r) / 256 rounded toward zero, saturated
  function automatic time_t sat_mul(time_t a, rate_t r);
    logic signed [MUL_BITS-1:0]   p;
    logic signed [MUL_BITS-1:0]   bias;
    logic signed [MUL_BITS-1:0]   adj;
    logic signed [Q_BITS-1:0]     q;
    logic [Q_BITS-TIME_BITS:0]    hi;
    p    = MUL_BITS'(a) * MUL_BITS'(r);
    bias = '0;
    bias[FRAC_BITS-1:0] = {FRAC_BITS{p[MUL_BITS-1]}};
    adj  = p + bias;
    q    = adj[MUL_BITS-1:FRAC_BITS];
    hi   = q[Q_BITS-1:TIME_BITS-1];
    if (&hi || ~|hi) begin
      return q[TIME_BITS-1:0];
    end
    return q[Q_BITS-1] ? T_MIN : T_MAX;
  endfunction

  function automatic time_t play_time(pstate_e m, time_t t, rate_t r,
                                      time_t ad, logic inf);
    time_t res;
    res = t;
    if (r > 0) begin
      if (m == ST_FINISHED || (!inf && t >= ad) || t < 0) res = '0;
    end else begin
      if ((m == ST_FINISHED || t <= 0 || (!inf && t > ad)) && !inf) res = ad;
    end
    return res;
  endfunction

  time_t ad;
  logic  inf;
  time_t tick_time;
  rate_t rev_rate;
  time_t set_cmp;

  assign ad  = timing_i.active_dur;
  assign inf = timing_i.infinite;

  always_comb begin
    tick_time = sat_add(state_i.anim_time, sat_mul(item_i.delta_time, state_i.rate));
    rev_rate  = (state_i.rate == R_MIN) ? R_MAX : -state_i.rate;
    set_cmp   = inf ? INF_CMP_TIME : ad;
    state_o   = state_i;
    case (item_i.cmd)
      CMD_TICK: begin
        if (state_i.mode == ST_RUNNING) begin
          if (timing_i.timeline_present) begin
            state_o.clock_time = sat_add(state_i.clock_time, item_i.delta_time);
          end
          state_o.anim_time = tick_time;
          if (state_i.rate > 0) begin
            if (!inf && tick_time >= ad) begin
              state_o.anim_time = ad;
              state_o.mode      = ST_FINISHED;
            end
          end else if (tick_time <= 0) begin
            state_o.anim_time = '0;
            state_o.mode      = ST_FINISHED;
          end
        end
      end
      CMD_PLAY: begin
        state_o.anim_time = play_time(state_i.mode, state_i.anim_time,
                                      state_i.rate, ad, inf);
        state_o.mode      = ST_RUNNING;
      end
      CMD_PAUSE: begin
        if (state_i.mode == ST_RUNNING || state_i.mode == ST_PAUSED) begin
          state_o.mode = ST_PAUSED;
        end
      end
      CMD_REVERSE: begin
        state_o.rate      = rev_rate;
        state_o.anim_time = play_time(state_i.mode, state_i.anim_time,
                                      rev_rate, ad, inf);
        state_o.mode      = ST_RUNNING;
      end
      CMD_CANCEL: begin
        state_o.mode      = ST_IDLE;
        state_o.anim_time = '0;
      end
      CMD_FINISH: begin
        if (state_i.rate > 0) begin
          if (!inf) state_o.anim_time = ad;
        end else begin
          state_o.anim_time = '0;
        end
        state_o.mode = ST_FINISHED;
      end
      CMD_SET_TIME: begin
        state_o.anim_time = item_i.seek_time;
        if (state_i.mode == ST_FINISHED) begin
          if ((state_i.rate > 0 && item_i.seek_time < set_cmp) ||
              (state_i.rate <= 0 && item_i.seek_time > 0)) begin
            state_o.mode = ST_RUNNING;
          end
        end else if (state_i.mode == ST_RUNNING) begin
          if ((state_i.rate > 0 && !inf && item_i.seek_time >= ad) ||
              (state_i.rate <= 0 && item_i.seek_time <= 0)) begin
            state_o.mode = ST_FINISHED;
          end
        end
      end
      CMD_SET_RATE: begin
        state_o.rate = item_i.new_rate;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/apt_checker.sv
// ----------------------------------------------------------------------------
// apt_checker
// Port-level assertions for the animation playback timer.
// ----------------------------------------------------------------------------
`include "animation_playback_timer_top_defines.svh"

module apt_checker
  import apt_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [OUT_DATA_BITS-1:0] m_axis_tdata
);

  // stalled result keeps valid and data
  `APT_ASSERT_NEXT(a_out_hold_valid, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `APT_ASSERT_NEXT(a_out_hold_data, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result changed while stalled")
  // nothing pending at the output means the input side is open
  `APT_ASSERT_IMPL(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input blocked with empty output")
  // an accepted item reaches the output once the result slot frees up
  `APT_ASSERT_NEXT(a_item_moves, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) ##1 (!m_axis_tvalid || m_axis_tready), m_axis_tvalid, "accepted item did not produce a result")

endmodule

bind animation_playback_timer_top apt_checker u_apt_checker (.*);
